### rtl/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; every other rtl file refers to this package by scoped names.
package ptts_pkg;

    localparam int SLOT_W  = 3;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int MAX_SLOTS = 1 << SLOT_W;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ADD  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ACTION = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OCCUPIED  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              fired;
        logic [SLOT_W-1:0] task_res;
        logic              last;
    } rsp_word_t;

    typedef struct packed {
        logic              adv;
        logic              add_ok;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] initial_wait;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } cell_stat_t;

endpackage

### rtl/ptts_req_if.sv
// Request channel of the scheduler: valid/ready plus one input word.
// Depends on ptts_pkg for field widths.
interface ptts_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ptts_pkg::SLOT_W-1:0]   slot;
    logic [ptts_pkg::TIME_W-1:0]   period;
    logic [ptts_pkg::TIME_W-1:0]   initial_wait;
    logic                          has_action;

    modport source (output valid, mode, slot, period, initial_wait, has_action,
                    input ready);
    modport sink   (input valid, mode, slot, period, initial_wait, has_action,
                    output ready);
endinterface

### rtl/ptts_rsp_if.sv
// Response channel of the scheduler: valid/ready plus one result word.
// Depends on ptts_pkg for field widths.
interface ptts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptts_pkg::STAT_W-1:0]   status;
    logic                          fired;
    logic [ptts_pkg::SLOT_W-1:0]   task_res;
    logic                          last;

    modport source (output valid, status, fired, task_res, last, input ready);
    modport sink   (input valid, status, fired, task_res, last, output ready);
endinterface

### rtl/periodic_task_tick_scheduler_core.sv
// Periodic task tick scheduler, top level: request/response control and the
// chain of slot cells. Depends on ptts_pkg, ptts_req_if, ptts_rsp_if, ptts_cell.
//
// Usage:
//   req carries one word per item: mode 1 adds a task to a slot, mode 0 is a
//   scheduler tick. rsp returns result words; the final word of an item has
//   last set.
//   An add gives one word (status ok, no action or occupied) in the cycle
//   after it is taken. A tick sends a token down the chain of NUM_TASKS cells, one
//   cell per cycle unless the walk pauses; each valid cell bumps its counter
//   and may fire. Fired slots come out in slot order, lowest first; if none
//   fire, one empty word with last set is sent. A tick walks the token
//   through every cell, then sends its last word; a stalled rsp can delay it.
//   One item is in work at a time; req.ready is low until the last word of
//   the current item is in the output register.
//   A stalled rsp holds its word; the walk pauses only when a second fired
//   slot is found while the output register is still full.
//   Reset clears all slots (no task registered, counters zero, wait phase).
module periodic_task_tick_scheduler_core #(
    parameter int NUM_TASKS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ptts_req_if.sink     req,
    ptts_rsp_if.source   rsp
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int NSLOT = (NUM_TASKS < ptts_pkg::MAX_SLOTS) ? NUM_TASKS
                                                             : ptts_pkg::MAX_SLOTS;

    ptts_pkg::state_t      state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    ptts_pkg::rsp_word_t   rsp_word_reg, rsp_word_next;
    logic                  rsp_load;

    ptts_pkg::cell_ctl_t   ctl;
    ptts_pkg::cell_stat_t  stat [NUM_TASKS];
    logic [NUM_TASKS-1:0]  tok_vec;
    logic [NUM_TASKS-1:0]  hit_vec;
    logic [NUM_TASKS-1:0]  valid_vec;

    logic                  out_free;
    logic                  acc;
    logic                  start;
    logic                  hit_any;
    logic                  stall;
    logic                  walk_adv;
    logic                  last_pos;
    logic                  slot_free;
    logic [ptts_pkg::STAT_W-1:0] add_status;

    // cell chain
    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        logic tok_in;
        if (i == 0)
        begin : g_head
            assign tok_in = start;
        end
        else
        begin : g_link
            assign tok_in = tok_vec[i-1];
        end

        ptts_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok_in),
            .tok_out (tok_vec[i]),
            .stat    (stat[i])
        );

        assign hit_vec[i]   = stat[i].hit;
        assign valid_vec[i] = stat[i].valid;
    end

    always_comb
    begin
        slot_free = 1'b0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if ((req.slot == ptts_pkg::SLOT_W'(i)) && !valid_vec[i])
            begin
                slot_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (!req.has_action)
        begin
            add_status = ptts_pkg::STAT_NO_ACTION;
        end
        else if (!slot_free)
        begin
            add_status = ptts_pkg::STAT_OCCUPIED;
        end
        else
        begin
            add_status = ptts_pkg::STAT_OK;
        end
    end

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ptts_pkg::S_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign start     = acc && (req.mode == ptts_pkg::MODE_TICK);
    assign hit_any   = |hit_vec;
    assign stall     = hit_any && pend_valid_reg && !out_free;
    assign walk_adv  = (state_reg == ptts_pkg::S_WALK) && !stall;
    assign last_pos  = (idx_reg == IDX_W'(NUM_TASKS - 1));

    assign ctl.adv          = start || walk_adv;
    assign ctl.add_ok       = acc && (req.mode == ptts_pkg::MODE_ADD)
                              && (add_status == ptts_pkg::STAT_OK);
    assign ctl.slot         = req.slot;
    assign ctl.period       = req.period;
    assign ctl.initial_wait = req.initial_wait;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ptts_pkg::S_WALK;
                end
            end
            ptts_pkg::S_WALK:
            begin
                if (walk_adv && last_pos)
                begin
                    state_next = ptts_pkg::S_FLUSH;
                end
            end
            ptts_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ptts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptts_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        rsp_load        = 1'b0;
        rsp_word_next   = rsp_word_reg;
        unique case (state_reg)
            ptts_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (acc && (req.mode == ptts_pkg::MODE_ADD))
                begin
                    rsp_load               = 1'b1;
                    rsp_word_next.status   = add_status;
                    rsp_word_next.fired    = 1'b0;
                    rsp_word_next.task_res = '0;
                    rsp_word_next.last     = 1'b1;
                end
            end
            ptts_pkg::S_WALK:
            begin
                if (walk_adv)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (hit_any)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        if (pend_valid_reg)
                        begin
                            rsp_load               = 1'b1;
                            rsp_word_next.status   = ptts_pkg::STAT_OK;
                            rsp_word_next.fired    = 1'b1;
                            rsp_word_next.task_res = ptts_pkg::SLOT_W'(pend_idx_reg);
                            rsp_word_next.last     = 1'b0;
                        end
                    end
                end
            end
            ptts_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    rsp_load               = 1'b1;
                    rsp_word_next.status   = ptts_pkg::STAT_OK;
                    rsp_word_next.fired    = pend_valid_reg;
                    rsp_word_next.task_res = pend_valid_reg
                                             ? ptts_pkg::SLOT_W'(pend_idx_reg) : '0;
                    rsp_word_next.last     = 1'b1;
                    pend_valid_next        = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptts_pkg::S_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (rsp_load)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_word_reg.status;
    assign rsp.fired    = rsp_word_reg.fired;
    assign rsp.task_res = rsp_word_reg.task_res;
    assign rsp.last     = rsp_word_reg.last;

    // checks
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the walk token");

    a_hit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        hit_any |-> (state_reg == ptts_pkg::S_WALK))
        else $error("slot fired outside a tick walk");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptts_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("fired word left pending after a tick");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ptts_pkg::S_FLUSH) && out_free) |=> (rsp.valid && rsp.last))
        else $error("tick ended without a last word");

endmodule

### rtl/ptts_cell.sv
// One task slot of the scheduler chain: holds period, wait, phase and counter,
// and passes the walk token to its neighbor. Depends on ptts_pkg.
module ptts_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptts_pkg::cell_ctl_t   ctl,
    input  logic                  tok_in,
    output logic                  tok_out,
    output ptts_pkg::cell_stat_t  stat
);

    logic                          tok_reg;
    logic                          valid_reg;
    logic                          running_reg;
    logic [ptts_pkg::TIME_W-1:0]   count_reg;
    logic [ptts_pkg::TIME_W-1:0]   period_reg;
    logic [ptts_pkg::TIME_W-1:0]   wait_reg;

    logic [ptts_pkg::TIME_W-1:0]   cnt_inc;
    logic [ptts_pkg::TIME_W-1:0]   limit;
    logic                          hit;
    logic                          wr;

    assign cnt_inc = count_reg + ptts_pkg::TIME_W'(1);
    assign limit   = running_reg ? period_reg : wait_reg;
    assign hit     = tok_reg && valid_reg && (cnt_inc >= limit);
    assign wr      = (IDX < ptts_pkg::MAX_SLOTS) && ctl.add_ok
                     && (ctl.slot == ptts_pkg::SLOT_W'(IDX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            running_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (wr)
            begin
                valid_reg <= 1'b1;
            end
            if (ctl.adv)
            begin
                tok_reg <= tok_in;
                if (tok_reg && valid_reg)
                begin
                    count_reg <= hit ? '0 : cnt_inc;
                    if (hit)
                    begin
                        running_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            period_reg <= ctl.period;
            wait_reg   <= ctl.initial_wait;
        end
    end

    assign tok_out    = tok_reg;
    assign stat.valid = valid_reg;
    assign stat.hit   = hit;

endmodule
